FILE: rtl/ccrc_pkg.sv
`timescale 1ns / 1ps

package ccrc_pkg;

    localparam int CRC_W  = 32;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 3;

    // width mode codes (code 3 behaves as 32 bits)
    localparam logic [1:0] MODE_CRC8  = 2'd0;
    localparam logic [1:0] MODE_CRC16 = 2'd1;
    localparam logic [1:0] MODE_CRC32 = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_XOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_IN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_OUT = 3'd5;

    // reset values; common presets: CRC-8 0x07/0x31, CRC-16 0x8005/0x1021/0x3d65,
    // CRC-32 0x04c11db7
    localparam logic [1:0]       RST_WIDTH_MODE = MODE_CRC8;
    localparam logic [CRC_W-1:0] RST_POLYNOMIAL = 32'h0000_0007;

    typedef struct packed {
        logic [1:0]       width_mode;
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] init_value;
        logic [CRC_W-1:0] final_xor;
        logic             reflect_input;
        logic             reflect_output;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_data;
        logic              is_last;
    } t_item;

endpackage

FILE: rtl/configurable_crc_engine_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_data_byte, i_has_data, i_is_last
// out      output     o_out_valid / i_out_ready o_crc_value
// cfg      input      i_cfg_we (no wait)        i_cfg_index, i_cfg_wdata
//
// One byte per cycle unless a last item waits on a stalled output: each transfer
// lands in the input register and is folded into the running CRC through eight
// unrolled XOR-shift steps, and a last item's result into the o_crc_value register.
// An output stall holds only items that produce a result; other items keep flowing.
// Reset (synchronous, active low) clears both stages and the message state, presets cfg.

module configurable_crc_engine_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ccrc_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                i_has_data,
    input  logic                                i_is_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ccrc_pkg::CRC_W-1:0]          o_crc_value,
    input  logic                                i_cfg_we,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ccrc_pkg::CRC_W-1:0]          i_cfg_wdata
);

    ccrc_pkg::t_cfg             r_cfg;
    ccrc_pkg::t_item            r_item;
    logic                       r_item_valid;
    logic                       r_inside;
    logic [ccrc_pkg::CRC_W-1:0] r_running_crc;
    logic                       r_out_valid;
    logic [ccrc_pkg::CRC_W-1:0] r_crc_value;

    logic [ccrc_pkg::CRC_W-1:0] n_running_crc;
    logic [ccrc_pkg::CRC_W-1:0] n_crc_value;
    logic                       out_free;
    logic                       advance;
    logic                       in_xfer;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_item_valid && (!r_item.is_last || out_free);
    assign o_in_ready = !r_item_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_mode     <= ccrc_pkg::RST_WIDTH_MODE;
            r_cfg.polynomial     <= ccrc_pkg::RST_POLYNOMIAL;
            r_cfg.init_value     <= '0;
            r_cfg.final_xor      <= '0;
            r_cfg.reflect_input  <= 1'b0;
            r_cfg.reflect_output <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ccrc_pkg::CFG_WIDTH_MODE:  r_cfg.width_mode     <= i_cfg_wdata[1:0];
                ccrc_pkg::CFG_POLYNOMIAL:  r_cfg.polynomial     <= i_cfg_wdata;
                ccrc_pkg::CFG_INIT_VALUE:  r_cfg.init_value     <= i_cfg_wdata;
                ccrc_pkg::CFG_FINAL_XOR:   r_cfg.final_xor      <= i_cfg_wdata;
                ccrc_pkg::CFG_REFLECT_IN:  r_cfg.reflect_input  <= i_cfg_wdata[0];
                ccrc_pkg::CFG_REFLECT_OUT: r_cfg.reflect_output <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_xfer) begin
            r_item_valid <= 1'b1;
        end else if (advance) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.data_byte <= i_data_byte;
            r_item.has_data  <= i_has_data;
            r_item.is_last   <= i_is_last;
        end
    end

    ccrc_datapath u_datapath (
        .i_cfg         (r_cfg),
        .i_item        (r_item),
        .i_inside      (r_inside),
        .i_running_crc (r_running_crc),
        .o_next_crc    (n_running_crc),
        .o_result      (n_crc_value)
    );

    // message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside      <= 1'b0;
            r_running_crc <= '0;
        end else if (advance) begin
            r_inside      <= !r_item.is_last;
            r_running_crc <= n_running_crc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_item.is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_item.is_last) begin
            r_crc_value <= n_crc_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc_value;

endmodule

FILE: rtl/ccrc_datapath.sv
`timescale 1ns / 1ps

module ccrc_datapath (
    input  ccrc_pkg::t_cfg                  i_cfg,
    input  ccrc_pkg::t_item                 i_item,
    input  logic                            i_inside,
    input  logic [ccrc_pkg::CRC_W-1:0]      i_running_crc,
    output logic [ccrc_pkg::CRC_W-1:0]      o_next_crc,
    output logic [ccrc_pkg::CRC_W-1:0]      o_result
);

    function automatic logic [ccrc_pkg::BYTE_W-1:0] rev_byte(
        input logic [ccrc_pkg::BYTE_W-1:0] v
    );
        logic [ccrc_pkg::BYTE_W-1:0] r;
        for (int k = 0; k < ccrc_pkg::BYTE_W; k++) begin
            r[k] = v[ccrc_pkg::BYTE_W-1-k];
        end
        return r;
    endfunction

    function automatic logic [ccrc_pkg::CRC_W-1:0] rev_word(
        input logic [ccrc_pkg::CRC_W-1:0] v
    );
        logic [ccrc_pkg::CRC_W-1:0] r;
        for (int k = 0; k < ccrc_pkg::CRC_W; k++) begin
            r[k] = v[ccrc_pkg::CRC_W-1-k];
        end
        return r;
    endfunction

    logic [ccrc_pkg::CRC_W-1:0]  mask;
    logic [4:0]                  top_idx;
    logic [4:0]                  byte_shift;
    logic [4:0]                  rev_shift;
    logic [ccrc_pkg::CRC_W-1:0]  poly;
    logic [ccrc_pkg::BYTE_W-1:0] byte_in;
    logic [ccrc_pkg::CRC_W-1:0]  crc;
    logic [ccrc_pkg::CRC_W-1:0]  res;

    always_comb begin
        unique case (i_cfg.width_mode)
            ccrc_pkg::MODE_CRC8: begin
                mask       = 32'h0000_00FF;
                top_idx    = 5'd7;
                byte_shift = 5'd0;
                rev_shift  = 5'd24;
            end
            ccrc_pkg::MODE_CRC16: begin
                mask       = 32'h0000_FFFF;
                top_idx    = 5'd15;
                byte_shift = 5'd8;
                rev_shift  = 5'd16;
            end
            default: begin
                mask       = 32'hFFFF_FFFF;
                top_idx    = 5'd31;
                byte_shift = 5'd24;
                rev_shift  = 5'd0;
            end
        endcase
    end

    always_comb begin
        poly    = i_cfg.polynomial & mask;
        byte_in = i_cfg.reflect_input ? rev_byte(i_item.data_byte) : i_item.data_byte;
        crc     = i_inside ? (i_running_crc & mask) : (i_cfg.init_value & mask);

        if (i_item.has_data) begin
            crc = crc ^ ({{(ccrc_pkg::CRC_W-ccrc_pkg::BYTE_W){1'b0}}, byte_in} << byte_shift);
            // eight MSB-first polynomial steps
            for (int s = 0; s < ccrc_pkg::BYTE_W; s++) begin
                if (crc[top_idx]) begin
                    crc = ((crc << 1) ^ poly) & mask;
                end else begin
                    crc = (crc << 1) & mask;
                end
            end
        end

        // reversing all 32 bits and shifting down reflects over the selected width
        res = i_cfg.reflect_output ? (rev_word(crc) >> rev_shift) : crc;
        res = (res ^ i_cfg.final_xor) & mask;
    end

    assign o_next_crc = crc;
    assign o_result   = res;

endmodule

FILE: tb/sv/configurable_crc_engine_core_test.sv
`timescale 1ns / 1ps

module configurable_crc_engine_core_test;

    localparam int CRC_W        = ccrc_pkg::CRC_W;
    localparam int BYTE_W       = ccrc_pkg::BYTE_W;
    localparam int CFG_IDX_W    = ccrc_pkg::CFG_IDX_W;
    localparam int FOLD_CYCLES  = 6;
    localparam int RANDOM_ITEMS = 600;

    localparam logic [CRC_W-1:0] PRESET_POLYS [6] = '{
        32'h0000_0007, 32'h0000_0031, 32'h0000_8005,
        32'h0000_1021, 32'h0000_3d65, 32'h04c1_1db7
    };

    class crc_scoreboard;
        logic [1:0]       mode;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] init_val;
        logic [CRC_W-1:0] xor_out;
        logic             refl_in;
        logic             refl_out;
        logic [CRC_W-1:0] running;
        logic             open_msg;
        logic [CRC_W-1:0] crc_q[$];
        int               errors;
        int               crcs_checked;
        int               bytes_fed;

        function new();
            mode         = ccrc_pkg::RST_WIDTH_MODE;
            poly         = ccrc_pkg::RST_POLYNOMIAL;
            init_val     = '0;
            xor_out      = '0;
            refl_in      = 1'b0;
            refl_out     = 1'b0;
            running      = '0;
            open_msg     = 1'b0;
            errors       = 0;
            crcs_checked = 0;
            bytes_fed    = 0;
        endfunction

        function logic [CRC_W-1:0] mirror(logic [CRC_W-1:0] v, int unsigned w);
            logic [CRC_W-1:0] r;
            r = '0;
            for (int i = 0; i < w; i++) r[w-1-i] = v[i];
            return r;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CRC_W-1:0] val);
            case (idx)
                ccrc_pkg::CFG_WIDTH_MODE:  mode     = val[1:0];
                ccrc_pkg::CFG_POLYNOMIAL:  poly     = val;
                ccrc_pkg::CFG_INIT_VALUE:  init_val = val;
                ccrc_pkg::CFG_FINAL_XOR:   xor_out  = val;
                ccrc_pkg::CFG_REFLECT_IN:  refl_in  = val[0];
                ccrc_pkg::CFG_REFLECT_OUT: refl_out = val[0];
                default: ;
            endcase
        endfunction

        // fold one transfer into the running CRC, queue the finished value on last
        function void note_item(logic [BYTE_W-1:0] data, logic has, logic last);
            int unsigned      w;
            logic [CRC_W-1:0] mask;
            logic [CRC_W-1:0] top;
            logic [CRC_W-1:0] p;
            logic [CRC_W-1:0] crc;
            logic [CRC_W-1:0] res;
            logic [BYTE_W-1:0] b;
            case (mode)
                ccrc_pkg::MODE_CRC8:  w = 8;
                ccrc_pkg::MODE_CRC16: w = 16;
                default:              w = 32;
            endcase
            mask = (w == CRC_W) ? '1 : ((CRC_W'(1) << w) - 1);
            top  = CRC_W'(1) << (w - 1);
            p    = poly & mask;
            crc  = open_msg ? (running & mask) : (init_val & mask);
            if (has) begin
                b = refl_in ? BYTE_W'(mirror(CRC_W'(data), 8)) : data;
                crc = crc ^ (CRC_W'(b) << (w - 8));
                for (int i = 0; i < 8; i++) begin
                    if ((crc & top) != 0) crc = ((crc << 1) ^ p) & mask;
                    else crc = (crc << 1) & mask;
                end
                bytes_fed++;
            end
            if (last) begin
                res = refl_out ? mirror(crc, w) : crc;
                crc_q.push_back((res ^ xor_out) & mask);
            end
            running  = crc;
            open_msg = !last;
        endfunction

        function void check_result(logic [CRC_W-1:0] got);
            logic [CRC_W-1:0] want;
            if (crc_q.size() == 0) begin
                $display("%0t: crc %08h with nothing outstanding, expected none", $time, got);
                errors++;
                return;
            end
            want = crc_q.pop_front();
            crcs_checked++;
            if (got !== want) begin
                $display("%0t: crc mismatch: expected %08h, actual %08h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 i_has_data;
    logic                 i_is_last;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CRC_W-1:0]     o_crc_value;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CRC_W-1:0]     i_cfg_wdata;

    crc_scoreboard sb = new();
    int in_gap_max  = 6;
    int out_gap_max = 6;
    int items_sent  = 0;
    int settings    = 1;

    configurable_crc_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_has_data  (i_has_data),
        .i_is_last   (i_is_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_crc_value (o_crc_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_crc_value);
    end

    // result side: stall for a random number of cycles before each transfer
    initial begin
        int gap;
        forever begin
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid && i_out_ready));
        end
    end

    task automatic send_item(input logic [BYTE_W-1:0] data, input logic has,
                             input logic last);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        i_has_data  <= has;
        i_is_last   <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(data, has, last);
        items_sent++;
    endtask

    // hold off until every CRC is out and the last byte has folded through
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.crc_q.size() != 0) @(posedge i_clk);
        repeat (FOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    function automatic logic [CRC_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_settings(input bit write_all);
        logic [CFG_IDX_W-1:0] idx;
        logic [CRC_W-1:0]     val;
        for (int r = 0; r <= int'(ccrc_pkg::CFG_REFLECT_OUT); r++) begin
            idx = r[CFG_IDX_W-1:0];
            if (write_all || $urandom_range(0, 3) != 0) begin
                case (idx) inside
                    ccrc_pkg::CFG_WIDTH_MODE: val = CRC_W'($urandom_range(0, 3));
                    ccrc_pkg::CFG_POLYNOMIAL: val = ($urandom_range(0, 1) == 0) ?
                                          PRESET_POLYS[$urandom_range(0, 5)] : pick_word();
                    ccrc_pkg::CFG_REFLECT_IN, ccrc_pkg::CFG_REFLECT_OUT:
                        val = CRC_W'($urandom_range(0, 1));
                    default: val = pick_word();
                endcase
                cfg_write(idx, val);
            end
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_random_message(input bit close);
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        for (int k = 0; k < len; k++)
            send_item(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) != 0, 1'b0);
        if (close)
            send_item(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 4) != 0, 1'b1);
    endtask

    initial begin
        int base;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        i_has_data  <= 1'b0;
        i_is_last   <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= ccrc_pkg::CFG_WIDTH_MODE;
        i_cfg_wdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plain CRC-8, poly 0x07
        send_item(8'h00, 1'b0, 1'b1);   // empty message gives the init value
        send_item(8'hA5, 1'b0, 1'b1);   // byte ignored without has_data
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h31, 1'b1, 1'b0);
        send_item(8'h32, 1'b1, 1'b1);
        drain();

        // CRC-16, both reflections, wide values must be masked down
        cfg_write(ccrc_pkg::CFG_WIDTH_MODE, CRC_W'(ccrc_pkg::MODE_CRC16));
        cfg_write(ccrc_pkg::CFG_POLYNOMIAL, 32'hFFFF_8005);
        cfg_write(ccrc_pkg::CFG_INIT_VALUE, '1);
        cfg_write(ccrc_pkg::CFG_FINAL_XOR, 32'h1234_FFFF);
        cfg_write(ccrc_pkg::CFG_REFLECT_IN, 32'd1);
        cfg_write(ccrc_pkg::CFG_REFLECT_OUT, 32'd1);
        i_cfg_we <= 1'b0;
        send_item(8'h31, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);   // empty item inside a message
        send_item(8'h39, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);   // leave this message open
        drain();

        // retune with the message open: unused width code, new init must not load
        cfg_write(ccrc_pkg::CFG_WIDTH_MODE, 32'd3);
        cfg_write(ccrc_pkg::CFG_POLYNOMIAL, 32'h04c1_1db7);
        cfg_write(ccrc_pkg::CFG_INIT_VALUE, 32'h0);
        cfg_write(ccrc_pkg::CFG_REFLECT_IN, 32'd0);
        i_cfg_we <= 1'b0;
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        drain();

        cfg_write(ccrc_pkg::CFG_WIDTH_MODE, CRC_W'(ccrc_pkg::MODE_CRC32));
        cfg_write(ccrc_pkg::CFG_POLYNOMIAL, '1);
        cfg_write(ccrc_pkg::CFG_INIT_VALUE, '1);
        cfg_write(ccrc_pkg::CFG_FINAL_XOR, '0);
        cfg_write(ccrc_pkg::CFG_REFLECT_OUT, 32'd0);
        i_cfg_we <= 1'b0;
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        drain();

        cfg_write(ccrc_pkg::CFG_WIDTH_MODE, CRC_W'(ccrc_pkg::MODE_CRC8));
        cfg_write(ccrc_pkg::CFG_POLYNOMIAL, '0);
        i_cfg_we <= 1'b0;
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b1);
        drain();
        settings += 4;

        base = items_sent;
        random_settings(1'b1);
        while (items_sent - base < RANDOM_ITEMS) begin
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat ($urandom_range(2, 10)) send_random_message(1'b1);
            if ($urandom_range(0, 2) == 0) send_random_message(1'b0);
            drain();
            random_settings(1'b0);
        end
        send_random_message(1'b1);
        drain();

        $display("Fed %0d bytes in %0d transfers; %0d CRCs checked over %0d register settings",
                 sb.bytes_fed, items_sent, sb.crcs_checked, settings);
        $display("(8/16/32-bit and unused width code, reflected and plain, mid-message retunes)");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ccrc_pkg.sv
rtl/ccrc_datapath.sv
rtl/configurable_crc_engine_core.sv
tb/sv/configurable_crc_engine_core_test.sv
